// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the flight event detector RTL.
// Every macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset
`define FED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define FED_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fed_pkg.sv =====
// Flight event detector package: widths, register indexes, reset values and types.
// No dependencies.
package fed_pkg;

    localparam int TIME_W = 32;
    localparam int ALT_W  = 25;
    localparam int VEL_W  = 21;
    localparam int THR_W  = 20;
    localparam int NUM_W  = 35;
    localparam int MAG_W  = 26;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DIV_STEPS = 35;
    localparam int DIV_CNT_W = 6;

    localparam logic [THR_W-1:0] VEL_SAT = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_LIFTOFF_VEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APOGEE_VEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_ALT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LANDED_VEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LANDED_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLARE_ALT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT   = 3'd7;

    localparam logic [THR_W-1:0]         RST_LIFTOFF_VEL = 20'd200;
    localparam logic [THR_W-1:0]         RST_APOGEE_VEL  = 20'd100;
    localparam logic signed [ALT_W-1:0]  RST_TOUCH_ALT   = 25'sd50;
    localparam logic [THR_W-1:0]         RST_LANDED_VEL  = 20'd30;
    localparam logic [TIME_W-1:0]        RST_LANDED_HOLD = 32'd3000;
    localparam logic signed [ALT_W-1:0]  RST_FLARE_ALT   = 25'sd30000;
    localparam logic signed [ALT_W-1:0]  RST_ALT_LIMIT   = 25'sd10000000;
    localparam logic [THR_W-1:0]         RST_VEL_LIMIT   = 20'd1000000;

    typedef struct packed {
        logic [THR_W-1:0]        liftoff_vel;
        logic [THR_W-1:0]        apogee_vel;
        logic signed [ALT_W-1:0] touch_alt;
        logic [THR_W-1:0]        landed_vel;
        logic [TIME_W-1:0]       landed_hold;
        logic signed [ALT_W-1:0] flare_alt;
        logic signed [ALT_W-1:0] alt_limit;
        logic [THR_W-1:0]        vel_limit;
    } t_cfg;

endpackage

// ===== hdl/flight_event_detector_top.sv =====
// Flight event detector top level: sequencer, detector state and stream ports.
// Depends on fed_pkg, fed_cfg, fed_div and assert_macros.svh.
//
// Usage:
//   Input stream (s): one item per transfer. tdata holds now_ms [31:0],
//   altitude_cm [56:32], in_flight [57]; tuser holds has_altitude.
//   Output stream (m): exactly one result per input item, in order.
//   Config channel: write register i_cfg_index with i_cfg_data while idle;
//   o_cfg_ready is high whenever reset is released.
//   Work per item: a barometer sample with a usable previous timestamp runs
//   the divider (states MUL and DIV, one quotient bit per step) before FIN
//   forms the result; any other item goes straight from IDLE to FIN.
//   The input is not ready while an item is at work; it is ready again as
//   soon as the result sits in the output register, even if not yet taken.
//   If the receiver stalls, the next item finishes its work and then holds
//   until the output register frees up.
//   Reset (synchronous, active low) loads default thresholds and clears the
//   velocity, altitude, peak, phase and timer state; both ready outputs stay
//   low while reset is held.
`include "assert_macros.svh"
module flight_event_detector_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // now_ms [31:0], altitude_cm [56:32], in_flight [57], zero [63:58]
    input  logic [fed_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // has_altitude [0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // liftoff [0], apogee [1], flare [2], touchdown [3], landed [4],
    // altitude_limit [5], velocity_limit [6], velocity_cms [27:7],
    // peak_altitude_cm [52:28], zero [55:53]
    output logic [fed_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fed_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    fed_pkg::t_cfg w_cfg;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    logic [fed_pkg::TIME_W-1:0]          r_now;
    logic                                r_has;
    logic signed [fed_pkg::ALT_W-1:0]    r_alt;
    logic                                r_fly;
    logic [fed_pkg::MAG_W-1:0]           r_mag;
    logic                                r_neg;
    logic [fed_pkg::TIME_W-1:0]          r_dt;
    logic signed [fed_pkg::ALT_W-1:0]    r_held;
    logic signed [fed_pkg::ALT_W-1:0]    r_prev_alt;
    logic [fed_pkg::TIME_W-1:0]          r_prev_time;
    logic signed [fed_pkg::VEL_W-1:0]    r_vel;
    logic signed [fed_pkg::ALT_W-1:0]    r_peak;
    logic [3:0]                          r_phase;
    logic [fed_pkg::TIME_W-1:0]          r_stable;
    logic                                r_was;
    logic                                r_out_valid;
    logic [fed_pkg::OUT_TDATA_W-1:0]     r_out_data;

    logic                                w_accept;
    logic signed [fed_pkg::ALT_W-1:0]    w_in_alt;
    logic [fed_pkg::TIME_W-1:0]          w_in_now;
    logic [fed_pkg::TIME_W-1:0]          w_dt;
    logic signed [fed_pkg::MAG_W-1:0]    w_diff;
    logic [fed_pkg::MAG_W-1:0]           w_abs_diff;
    logic                                w_need_div;
    logic [fed_pkg::NUM_W-1:0]           w_prod;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [fed_pkg::NUM_W-1:0]           w_div_quo;
    logic [fed_pkg::THR_W-1:0]           w_sat_mag;
    logic signed [fed_pkg::VEL_W-1:0]    w_new_vel;
    logic                                w_fin_go;

    logic signed [fed_pkg::ALT_W-1:0]    w_alt;
    logic [fed_pkg::VEL_W-1:0]           w_spd;
    logic signed [fed_pkg::ALT_W-1:0]    w_peak_out;
    logic signed [fed_pkg::ALT_W-1:0]    n_peak;
    logic [3:0]                          n_phase;
    logic [fed_pkg::TIME_W-1:0]          n_stable;
    logic [6:0]                          w_ev;
    logic [fed_pkg::TIME_W-1:0]          w_elapsed;

    fed_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    fed_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign o_cfg_ready = i_rst_n;
    assign o_s_tready  = i_rst_n && (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_in_now   = i_s_tdata[fed_pkg::TIME_W-1:0];
    assign w_in_alt   = i_s_tdata[fed_pkg::TIME_W +: fed_pkg::ALT_W];
    assign w_dt       = w_in_now - r_prev_time;
    assign w_diff     = {w_in_alt[fed_pkg::ALT_W-1], w_in_alt}
                      - {r_prev_alt[fed_pkg::ALT_W-1], r_prev_alt};
    assign w_abs_diff = w_diff[fed_pkg::MAG_W-1] ? 26'(-w_diff) : 26'(w_diff);
    assign w_need_div = i_s_tuser && (r_prev_time != '0)
                      && (w_dt >= fed_pkg::TIME_W'(2));

    // Magnitude times 1000 feeds the divider
    assign w_prod      = {9'd0, r_mag} * 35'd1000;
    assign w_div_start = (r_state == ST_MUL);

    assign w_sat_mag = (w_div_quo > fed_pkg::NUM_W'(fed_pkg::VEL_SAT))
                     ? fed_pkg::VEL_SAT : w_div_quo[fed_pkg::THR_W-1:0];
    assign w_new_vel = r_neg ? -$signed({1'b0, w_sat_mag}) : $signed({1'b0, w_sat_mag});

    assign w_fin_go = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_div ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Event evaluation on the sample's altitude (or the held one if absent) and current velocity
    always_comb begin
        w_alt      = r_has ? r_alt : r_held;
        w_spd      = r_vel[fed_pkg::VEL_W-1] ? 21'(-r_vel) : 21'(r_vel);
        w_peak_out = (w_alt > r_peak) ? w_alt : r_peak;
        n_phase    = r_phase;
        n_stable   = r_stable;
        w_ev       = '0;
        w_elapsed  = '0;
        if (r_fly) begin
            if (!n_phase[0] && ($signed({r_vel[fed_pkg::VEL_W-1], r_vel})
                    > $signed({2'b00, w_cfg.liftoff_vel}))) begin
                n_phase[0] = 1'b1;
                w_ev[0]    = 1'b1;
            end
            if (n_phase[0] && !n_phase[1] && r_vel[fed_pkg::VEL_W-1]
                    && (w_spd > {1'b0, w_cfg.apogee_vel})) begin
                n_phase[1] = 1'b1;
                w_ev[1]    = 1'b1;
            end
            if (n_phase[1] && !n_phase[2] && (w_alt <= w_cfg.flare_alt)) begin
                n_phase[2] = 1'b1;
                w_ev[2]    = 1'b1;
            end
            if (n_phase[2] && !n_phase[3] && (w_alt <= w_cfg.touch_alt)) begin
                n_phase[3] = 1'b1;
                n_stable   = r_now;
                w_ev[3]    = 1'b1;
            end
            if (n_phase[3]) begin
                w_elapsed = r_now - n_stable;
                if (w_spd < {1'b0, w_cfg.landed_vel}) begin
                    w_ev[4] = (w_elapsed > w_cfg.landed_hold);
                end else begin
                    n_stable = r_now;
                end
            end
            w_ev[5] = (w_alt > w_cfg.alt_limit);
            w_ev[6] = (w_spd > {1'b0, w_cfg.vel_limit});
        end
        n_peak = w_peak_out;
        // Flight entry clears the detector after the result is formed
        if (r_fly && !r_was) begin
            n_peak   = '0;
            n_phase  = '0;
            n_stable = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_prev_alt  <= '0;
            r_prev_time <= '0;
            r_vel       <= '0;
            r_peak      <= '0;
            r_phase     <= '0;
            r_stable    <= '0;
            r_was       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == ST_DIV) && w_div_done) begin
                r_vel <= w_new_vel;
            end
            if (w_fin_go) begin
                if (r_has) begin
                    r_held      <= r_alt;
                    r_prev_alt  <= r_alt;
                    r_prev_time <= r_now;
                end
                r_peak   <= n_peak;
                r_phase  <= n_phase;
                r_stable <= n_stable;
                r_was    <= r_fly;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= w_in_now;
            r_has <= i_s_tuser;
            r_alt <= w_in_alt;
            r_fly <= i_s_tdata[fed_pkg::TIME_W + fed_pkg::ALT_W];
            r_mag <= w_abs_diff;
            r_neg <= w_diff[fed_pkg::MAG_W-1];
            r_dt  <= w_dt;
        end
        if (w_fin_go) begin
            r_out_data <= {3'b000, w_peak_out, r_vel, w_ev};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `FED_ASSERT(a_vel_range, (r_vel >= -21'sd1000000) && (r_vel <= 21'sd1000000),
        "velocity estimate outside saturation range")
    `FED_ASSERT(a_phase_order,
        (!r_phase[3] || r_phase[2]) && (!r_phase[2] || r_phase[1]) && (!r_phase[1] || r_phase[0]),
        "phase flags out of order")
    `FED_ASSERT_NEXT(a_div_wait, (r_state == ST_DIV) && !w_div_done, r_state == ST_DIV,
        "left divide wait before quotient")
    `FED_ASSERT_NEXT(a_out_busy_hold, (r_state == ST_FIN) && r_out_valid && !i_m_tready,
        (r_state == ST_FIN) && r_out_valid, "result dropped while output stalled")

endmodule

// ===== hdl/fed_cfg.sv =====
// Configuration register bank of the flight event detector.
// Depends on fed_pkg.
module fed_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [fed_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0] i_data,
    output fed_pkg::t_cfg                  o_cfg
);

    fed_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.liftoff_vel <= fed_pkg::RST_LIFTOFF_VEL;
            r_cfg.apogee_vel  <= fed_pkg::RST_APOGEE_VEL;
            r_cfg.touch_alt   <= fed_pkg::RST_TOUCH_ALT;
            r_cfg.landed_vel  <= fed_pkg::RST_LANDED_VEL;
            r_cfg.landed_hold <= fed_pkg::RST_LANDED_HOLD;
            r_cfg.flare_alt   <= fed_pkg::RST_FLARE_ALT;
            r_cfg.alt_limit   <= fed_pkg::RST_ALT_LIMIT;
            r_cfg.vel_limit   <= fed_pkg::RST_VEL_LIMIT;
        end else if (i_wr) begin
            case (i_index)
                fed_pkg::REG_LIFTOFF_VEL: r_cfg.liftoff_vel <= i_data[fed_pkg::THR_W-1:0];
                fed_pkg::REG_APOGEE_VEL:  r_cfg.apogee_vel  <= i_data[fed_pkg::THR_W-1:0];
                fed_pkg::REG_TOUCH_ALT:   r_cfg.touch_alt   <= i_data[fed_pkg::ALT_W-1:0];
                fed_pkg::REG_LANDED_VEL:  r_cfg.landed_vel  <= i_data[fed_pkg::THR_W-1:0];
                fed_pkg::REG_LANDED_HOLD: r_cfg.landed_hold <= i_data[fed_pkg::TIME_W-1:0];
                fed_pkg::REG_FLARE_ALT:   r_cfg.flare_alt   <= i_data[fed_pkg::ALT_W-1:0];
                fed_pkg::REG_ALT_LIMIT:   r_cfg.alt_limit   <= i_data[fed_pkg::ALT_W-1:0];
                fed_pkg::REG_VEL_LIMIT:   r_cfg.vel_limit   <= i_data[fed_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/fed_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on fed_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fed_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fed_pkg::NUM_W-1:0]   i_dividend,
    input  logic [fed_pkg::TIME_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [fed_pkg::NUM_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [fed_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [fed_pkg::NUM_W-1:0]     r_quo;
    logic [fed_pkg::TIME_W-1:0]    r_rem;
    logic [fed_pkg::TIME_W-1:0]    r_div;
    logic [fed_pkg::TIME_W:0]      w_shift;
    logic [fed_pkg::TIME_W:0]      w_sub;
    logic                          w_fits;

    assign w_shift = {r_rem, r_quo[fed_pkg::NUM_W-1]};
    assign w_sub   = w_shift - {1'b0, r_div};
    assign w_fits  = !w_sub[fed_pkg::TIME_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fed_pkg::DIV_CNT_W'(fed_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fed_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fed_pkg::NUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_sub[fed_pkg::TIME_W-1:0] : w_shift[fed_pkg::TIME_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `FED_ASSERT_IMPL(a_div_start_idle, i_start, !r_busy, "divider restarted while busy")
    `FED_ASSERT_IMPL(a_div_rem_bound, r_busy, r_rem < r_div, "remainder not below divisor")
    `FED_ASSERT_NEXT(a_div_done, r_busy && (r_cnt == fed_pkg::DIV_CNT_W'(1)), r_done && !r_busy,
        "divider did not finish after last step")

endmodule
